// ===== src/mbp_pkg.sv =====
// Shared constants for the MSB-first bit packer.
// No dependencies; every other file of the block but mbp_queue uses it.
package mbp_pkg;

   // Byte geometry
   localparam int BYTE_BITS = 8;
   localparam int CNT_WIDTH = 3;

   // Payload and register widths
   localparam int VALUE_WIDTH = 32;
   localparam int CFG_WIDTH   = 6;
   localparam logic [CFG_WIDTH-1:0] RESET_FIELD_WIDTH = 6'd11;

   // Default limits
   localparam int MAX_FIELD_WIDTH_DEFAULT = 32;
   localparam int QUEUE_DEPTH             = 2;

   // Request kinds
   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_FLUSH = 1'b1;

   // Result of one back-end step
   typedef struct packed {
      logic                 emits;
      logic                 last;
      logic                 done;
      logic [BYTE_BITS-1:0] data;
   } step_type;

endpackage

// ===== src/mbp_if.sv =====
// Valid/ready channel interfaces for requests and response bytes.
// Depends on mbp_pkg for field widths.
interface mbp_req_if;
   logic                            valid;
   logic                            ready;
   logic                            kind;
   logic [mbp_pkg::VALUE_WIDTH-1:0] value;

   modport source (output valid, kind, value, input ready);
   modport sink   (input valid, kind, value, output ready);
endinterface

interface mbp_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [mbp_pkg::BYTE_BITS-1:0] out_byte;
   logic                          last;

   modport source (output valid, out_byte, last, input ready);
   modport sink   (input valid, out_byte, last, output ready);
endinterface

// ===== src/mbp_front.sv =====
// Front end: holds the field width register, accepts requests and
// left-aligns the value bits for the back end. Depends on mbp_pkg, mbp_if.
module mbp_front #(
   parameter int MAX_FIELD_WIDTH = mbp_pkg::MAX_FIELD_WIDTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   mbp_req_if.sink                       req,
   input  logic                          csr_write_enable,
   input  logic [mbp_pkg::CFG_WIDTH-1:0] csr_write_data,
   output logic                          push_valid,
   output logic [MAX_FIELD_WIDTH + mbp_pkg::BYTE_BITS + $clog2(MAX_FIELD_WIDTH + 1):0] push_data,
   input  logic                          push_ready
);
   localparam int RW = $clog2(MAX_FIELD_WIDTH + 1);
   localparam int AW = MAX_FIELD_WIDTH + mbp_pkg::VALUE_WIDTH;

   logic [mbp_pkg::CFG_WIDTH-1:0] field_width_ff, field_width_in;
   logic [RW-1:0]                 width_eff;
   logic [AW-1:0]                 value_shifted;

   // Write the width register
   always_comb begin
      field_width_in = csr_write_enable ? csr_write_data : field_width_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         field_width_ff <= mbp_pkg::RESET_FIELD_WIDTH;
      end else begin
         field_width_ff <= field_width_in;
      end
   end

   // Saturate the width and move the field to the top of the word
   always_comb begin
      if (int'(field_width_ff) > MAX_FIELD_WIDTH) begin
         width_eff = RW'(MAX_FIELD_WIDTH);
      end else begin
         width_eff = RW'(field_width_ff);
      end
      value_shifted = AW'(req.value) << (RW'(MAX_FIELD_WIDTH) - width_eff);
   end

   // Hand the classified transaction to the queue
   assign push_valid = req.valid;
   assign req.ready  = push_ready;
   assign push_data  = {req.kind, width_eff, value_shifted[MAX_FIELD_WIDTH-1:0],
                        {mbp_pkg::BYTE_BITS{1'b0}}};
endmodule

// ===== src/mbp_queue.sv =====
// Small register queue between front and back end.
// Depends on nothing but its parameters.
module mbp_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   input  logic [WIDTH-1:0] push_data,
   output logic             push_ready,
   output logic             pop_valid,
   output logic [WIDTH-1:0] pop_data,
   input  logic             pop_ready
);
   localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNTW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTRW-1:0]  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNTW-1:0]  count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != CNTW'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Advance pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTRW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTRW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed entry
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end
endmodule

// ===== src/mbp_back.sv =====
// Back end: shifts queued field bits into the partial byte and emits
// one byte per cycle through an output register while the response port takes them. Depends on mbp_pkg, mbp_if.
module mbp_back #(
   parameter int MAX_FIELD_WIDTH = mbp_pkg::MAX_FIELD_WIDTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       pop_valid,
   input  logic [MAX_FIELD_WIDTH + mbp_pkg::BYTE_BITS + $clog2(MAX_FIELD_WIDTH + 1):0] pop_data,
   output logic       pop_ready,
   mbp_rsp_if.source  rsp
);
   localparam int BB = mbp_pkg::BYTE_BITS;
   localparam int CW = mbp_pkg::CNT_WIDTH;
   localparam int RW = $clog2(MAX_FIELD_WIDTH + 1);
   localparam int PW = MAX_FIELD_WIDTH + BB;
   localparam int XW = RW + 4;

   logic          busy_ff, busy_in;
   logic          kind_ff, kind_in;
   logic [RW-1:0] rem_ff, rem_in, rem_next;
   logic [PW-1:0] pend_ff, pend_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [BB-1:0] part_ff, part_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [BB-1:0] rsp_byte_ff, rsp_byte_in;
   logic          rsp_last_ff, rsp_last_in;

   logic [3:0]    room, take, sum;
   logic [BB-1:0] top_bits, new_bits, part_shift, write_byte;
   logic          out_free, fire, load;
   mbp_pkg::step_type step;

   // Work out how many bits this step takes and what it yields
   always_comb begin
      room       = 4'(BB) - {1'b0, cnt_ff};
      take       = (XW'(rem_ff) < XW'(room)) ? 4'(rem_ff) : room;
      top_bits   = pend_ff[PW-1 -: BB];
      new_bits   = top_bits >> (4'(BB) - take);
      part_shift = BB'({{BB{1'b0}}, part_ff} << take);
      write_byte = part_shift | new_bits;
      sum        = {1'b0, cnt_ff} + take;
      rem_next   = rem_ff - RW'(take);
      if (kind_ff == mbp_pkg::KIND_FLUSH) begin
         step.emits = (cnt_ff != '0);
         step.last  = 1'b1;
         step.done  = 1'b1;
         step.data  = BB'({{BB{1'b0}}, part_ff} << room);
      end else begin
         step.emits = (sum == 4'(BB));
         step.last  = (sum == 4'(BB)) && (XW'(rem_next) < XW'(BB));
         step.done  = (rem_next == '0);
         step.data  = write_byte;
      end
   end

   // Stall only on a step that emits into a full output register
   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign fire      = busy_ff && (!step.emits || out_free);
   assign pop_ready = !busy_ff || (fire && step.done);
   assign load      = pop_ready && pop_valid;

   // Advance the working transaction and the partial byte
   always_comb begin
      busy_in = busy_ff;
      kind_in = kind_ff;
      rem_in  = rem_ff;
      pend_in = pend_ff;
      cnt_in  = cnt_ff;
      part_in = part_ff;
      if (fire) begin
         if (kind_ff == mbp_pkg::KIND_FLUSH || step.emits) begin
            cnt_in  = '0;
            part_in = '0;
         end else begin
            cnt_in  = sum[CW-1:0];
            part_in = write_byte;
         end
         rem_in  = rem_next;
         pend_in = pend_ff << take;
      end
      if (load) begin
         busy_in = 1'b1;
         kind_in = pop_data[PW + RW];
         rem_in  = pop_data[PW +: RW];
         pend_in = pop_data[PW-1:0];
      end else if (fire && step.done) begin
         busy_in = 1'b0;
      end
   end

   // Hold the response until taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      if (fire && step.emits) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = step.data;
         rsp_last_in  = step.last;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         cnt_ff       <= '0;
         part_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         cnt_ff       <= cnt_in;
         part_ff      <= part_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      rem_ff      <= rem_in;
      pend_ff     <= pend_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp.valid    = rsp_valid_ff;
   assign rsp.out_byte = rsp_byte_ff;
   assign rsp.last     = rsp_last_ff;
endmodule

// ===== src/msb_first_bit_packer_core.sv =====
// MSB-first bit packer. A write request shifts the low field_width bits of its
// value (most significant first, saturated at MAX_FIELD_WIDTH) into a partial
// byte and emits each completed byte; a flush request pads a non-empty partial
// byte with zeros and emits it. The last byte of each request has last set.
// The back end handles a request in steps: each emits a completed byte or only
// gathers leftover bits, and a request that emits nothing still takes a step. A
// two-entry queue after the front end lets requests keep arriving while the
// response port stalls; the response is registered, and the request side
// accepts one transaction per cycle until the queue is full.
// Depends on mbp_pkg, mbp_if, mbp_front, mbp_queue and mbp_back.
module msb_first_bit_packer_core #(
   parameter int MAX_FIELD_WIDTH = mbp_pkg::MAX_FIELD_WIDTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   mbp_req_if.sink                       req_chan,
   mbp_rsp_if.source                     rsp_chan,
   input  logic                          csr_write_enable,
   input  logic [mbp_pkg::CFG_WIDTH-1:0] csr_write_data
);
   localparam int RW = $clog2(MAX_FIELD_WIDTH + 1);
   localparam int QW = 1 + RW + MAX_FIELD_WIDTH + mbp_pkg::BYTE_BITS;

   logic          push_valid, push_ready, pop_valid, pop_ready;
   logic [QW-1:0] push_data, pop_data;

   // Accept and classify requests
   mbp_front #(.MAX_FIELD_WIDTH(MAX_FIELD_WIDTH)) u_front (
      .clock            (clock),
      .reset            (reset),
      .req              (req_chan),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .push_valid       (push_valid),
      .push_data        (push_data),
      .push_ready       (push_ready)
   );

   // Decouple front and back
   mbp_queue #(.WIDTH(QW), .DEPTH(mbp_pkg::QUEUE_DEPTH)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_data   (pop_data),
      .pop_ready  (pop_ready)
   );

   // Pack bits and emit bytes
   mbp_back #(.MAX_FIELD_WIDTH(MAX_FIELD_WIDTH)) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_data  (pop_data),
      .pop_ready (pop_ready),
      .rsp       (rsp_chan)
   );
endmodule

// ===== src/mbp_checker.sv =====
// Port-level checks for the bit packer, bound to the top level.
// Depends on mbp_pkg and msb_first_bit_packer_core.
module mbp_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [mbp_pkg::BYTE_BITS-1:0] rsp_out_byte,
   input logic                          rsp_last
);
   // Hold a stalled response transaction
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_rsp_stable : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_out_byte) && $stable(rsp_last))
      else $error("response payload changed while stalled");

   // Leave reset with no response pending
   a_reset_idle : assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // Leave reset with an empty queue
   a_reset_ready : assert property (@(posedge clock) reset |=> req_ready)
      else $error("request not ready right after reset");
endmodule

bind msb_first_bit_packer_core mbp_checker u_mbp_checker (
   .clock        (clock),
   .reset        (reset),
   .req_ready    (req_chan.ready),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .rsp_out_byte (rsp_chan.out_byte),
   .rsp_last     (rsp_chan.last)
);

// ===== test/tb_msb_first_bit_packer_core.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for msb_first_bit_packer_core: directed and random
// write/flush traffic against a bit-level packing predictor, with random stalls.
// Depends on mbp_pkg, mbp_if and the packer RTL.
module tb_msb_first_bit_packer_core;

   localparam int HOLD_CYCLES   = 80;
   localparam int STALL_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 20;
   localparam int IDLE_PERCENT  = 12;
   localparam int PRINT_LIMIT   = 40;
   localparam int PHASE_ITEMS   = 45;

   typedef struct packed {
      logic [mbp_pkg::BYTE_BITS-1:0] data;
      logic                          last;
   } packed_byte_type;

   logic clock = 1'b0;
   logic reset;
   logic                          csr_write_enable;
   logic [mbp_pkg::CFG_WIDTH-1:0] csr_write_data;

   mbp_req_if req_chan();
   mbp_rsp_if rsp_chan();

   msb_first_bit_packer_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // Predictor state and expected bytes
   logic [mbp_pkg::CFG_WIDTH-1:0] field_width_model;
   logic [mbp_pkg::BYTE_BITS-1:0] gathered_bits;
   int                            gathered_count;
   packed_byte_type               bytes_expected[$];

   int error_count;
   bit gaps_on;
   bit hold_request;
   int hold_left;
   int quiet_cycles;

   // Clock: 12 ns period
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   task automatic report_mismatch(input string what);
      if (error_count < PRINT_LIMIT)
         $display("[%0t] mismatch: %s", $realtime, what);
      error_count++;
   endtask

   // Pack one accepted request into the expected byte stream
   function automatic void predict_bytes(input logic kind,
                                         input logic [mbp_pkg::VALUE_WIDTH-1:0] value);
      logic [mbp_pkg::BYTE_BITS-1:0] new_bytes[4];
      int                            produced;
      int                            nbits;
      produced = 0;
      if (kind == mbp_pkg::KIND_FLUSH) begin
         if (gathered_count != 0) begin
            new_bytes[0] = gathered_bits << (mbp_pkg::BYTE_BITS - gathered_count);
            produced = 1;
            gathered_bits = '0;
            gathered_count = 0;
         end
      end else begin
         nbits = (field_width_model > mbp_pkg::MAX_FIELD_WIDTH_DEFAULT) ?
                 mbp_pkg::MAX_FIELD_WIDTH_DEFAULT : int'(field_width_model);
         for (int pos = nbits - 1; pos >= 0; pos--) begin
            gathered_bits = {gathered_bits[mbp_pkg::BYTE_BITS-2:0], value[pos]};
            gathered_count++;
            if (gathered_count == mbp_pkg::BYTE_BITS) begin
               new_bytes[produced] = gathered_bits;
               produced++;
               gathered_bits = '0;
               gathered_count = 0;
            end
         end
      end
      for (int i = 0; i < produced; i++)
         bytes_expected.push_back('{data: new_bytes[i], last: (i == produced - 1)});
   endfunction

   function automatic logic [mbp_pkg::VALUE_WIDTH-1:0] pick_value();
      int sel;
      sel = $urandom_range(0, 7);
      if (sel == 0) return '0;
      if (sel == 1) return '1;
      return $urandom;
   endfunction

   // Offer one request after an optional random gap; return once accepted
   task automatic send_request(input logic kind,
                               input logic [mbp_pkg::VALUE_WIDTH-1:0] value);
      @(negedge clock);
      while (gaps_on && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.kind  <= kind;
      req_chan.value <= value;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      predict_bytes(kind, value);
   endtask

   // Drop valid, wait for every expected byte, then let the back end settle
   task automatic drain_packer();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (bytes_expected.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic program_field_width(input logic [mbp_pkg::CFG_WIDTH-1:0] width);
      drain_packer();
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= width;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      field_width_model = width;
   endtask

   // Receiver: random stalls, plus one long hold-off on request
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_chan.ready <= 1'b0;
         hold_left--;
      end else if (hold_request) begin
         rsp_chan.ready <= 1'b0;
         hold_left = HOLD_CYCLES - 1;
         hold_request = 1'b0;
      end else begin
         rsp_chan.ready <= !(gaps_on && $urandom_range(0, 99) < IDLE_PERCENT);
      end
   end

   // Compare each accepted byte with the oldest expectation
   always @(posedge clock) begin
      packed_byte_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (bytes_expected.size() == 0) begin
            report_mismatch($sformatf("unexpected byte %02h last=%0b",
                                      rsp_chan.out_byte, rsp_chan.last));
         end else begin
            want = bytes_expected.pop_front();
            if (rsp_chan.out_byte !== want.data)
               report_mismatch($sformatf("out_byte %02h, expected %02h",
                                         rsp_chan.out_byte, want.data));
            if (rsp_chan.last !== want.last)
               report_mismatch($sformatf("last %0b, expected %0b on byte %02h",
                                         rsp_chan.last, want.last, want.data));
         end
      end
   end

   // Watchdog: abort when no transaction moves for too long
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // Default width of 11 straight out of reset
   task automatic test_reset_width();
      send_request(mbp_pkg::KIND_WRITE, 32'h0000_07FF);
      send_request(mbp_pkg::KIND_WRITE, 32'h0000_0000);
      send_request(mbp_pkg::KIND_WRITE, 32'hFFFF_FFFF);
      send_request(mbp_pkg::KIND_WRITE, 32'h0000_0400);
      send_request(mbp_pkg::KIND_FLUSH, 32'h0000_0000);
   endtask

   // Flush with an empty buffer and with a partial byte
   task automatic test_flush_cases();
      send_request(mbp_pkg::KIND_FLUSH, 32'hFFFF_FFFF);
      send_request(mbp_pkg::KIND_WRITE, 32'h0000_05A5);
      send_request(mbp_pkg::KIND_FLUSH, 32'h1234_5678);
      send_request(mbp_pkg::KIND_FLUSH, 32'h0000_0000);
   endtask

   // Zero width, one bit, full word, saturation above the limit, one byte
   task automatic test_width_extremes();
      program_field_width(6'd0);
      send_request(mbp_pkg::KIND_WRITE, 32'hFFFF_FFFF);
      send_request(mbp_pkg::KIND_FLUSH, 32'h0000_0000);
      program_field_width(6'd1);
      send_request(mbp_pkg::KIND_WRITE, 32'h0000_0001);
      send_request(mbp_pkg::KIND_WRITE, 32'hFFFF_FFFE);
      send_request(mbp_pkg::KIND_WRITE, 32'h0000_0003);
      send_request(mbp_pkg::KIND_WRITE, 32'h8000_0001);
      send_request(mbp_pkg::KIND_FLUSH, 32'h0000_0000);
      program_field_width(6'd32);
      send_request(mbp_pkg::KIND_WRITE, 32'hFFFF_FFFF);
      send_request(mbp_pkg::KIND_WRITE, 32'h8000_0001);
      program_field_width(6'd63);
      send_request(mbp_pkg::KIND_WRITE, 32'h1234_5678);
      program_field_width(6'd33);
      send_request(mbp_pkg::KIND_WRITE, 32'hF000_0001);
      send_request(mbp_pkg::KIND_FLUSH, 32'h0000_0000);
      program_field_width(6'd8);
      send_request(mbp_pkg::KIND_WRITE, 32'h0000_00A5);
   endtask

   // Random writes and flushes over several width settings
   task automatic test_random_traffic();
      logic [mbp_pkg::CFG_WIDTH-1:0] width;
      gaps_on = 1'b1;
      for (int phase = 0; phase < 8; phase++) begin
         if (phase == 0)
            width = 6'd1;
         else if (phase == 1)
            width = 6'd32;
         else if (phase == 2)
            width = 6'd63;
         else if ($urandom_range(0, 9) < 7)
            width = mbp_pkg::CFG_WIDTH'($urandom_range(1, 32));
         else
            width = mbp_pkg::CFG_WIDTH'($urandom_range(33, 63));
         program_field_width(width);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if ($urandom_range(0, 99) < 15)
               send_request(mbp_pkg::KIND_FLUSH, $urandom);
            else
               send_request(mbp_pkg::KIND_WRITE, pick_value());
         end
      end
   endtask

   // Back-to-back stream at the default width, no idling on either side
   task automatic test_steady_stream();
      program_field_width(mbp_pkg::RESET_FIELD_WIDTH);
      gaps_on = 1'b0;
      for (int i = 0; i < 60; i++)
         send_request(mbp_pkg::KIND_WRITE, $urandom);
      send_request(mbp_pkg::KIND_FLUSH, 32'h0000_0000);
      gaps_on = 1'b1;
   endtask

   // Long receiver hold-off while full-word writes keep coming
   task automatic test_backpressure();
      program_field_width(6'd32);
      hold_request = 1'b1;
      for (int i = 0; i < 24; i++)
         send_request(mbp_pkg::KIND_WRITE, pick_value());
   endtask

   initial begin
      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      req_chan.valid   = 1'b0;
      req_chan.kind    = mbp_pkg::KIND_WRITE;
      req_chan.value   = '0;
      rsp_chan.ready   = 1'b0;
      field_width_model = mbp_pkg::RESET_FIELD_WIDTH;
      gathered_bits    = '0;
      gathered_count   = 0;
      error_count      = 0;
      gaps_on          = 1'b1;
      hold_request     = 1'b0;
      hold_left        = 0;
      quiet_cycles     = 0;

      // Hold reset, then release it
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      test_reset_width();
      test_flush_cases();
      test_width_extremes();
      test_steady_stream();
      test_backpressure();
      test_random_traffic();
      drain_packer();

      if (error_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
